// ===== hw/rtl/tfca_pkg.sv =====
// Types and constants shared by the two-frame command assembler.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package tfca_pkg;

	localparam logic [7:0]  TRAILER_MARK     = 8'h11;
	localparam logic [16:0] HZ_PER_TENTH_MHZ = 17'd100000;
	localparam logic [2:0]  PAYLOAD_LEN_TEST = 3'd5;
	localparam logic [2:0]  PAYLOAD_LEN_CFG  = 3'd0;

	localparam logic MSG_CONFIGURE = 1'b0;
	localparam logic MSG_TEST_DATA = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ID    = 2'd2;

	typedef struct packed {
		logic [10:0]     frame_id;
		logic [7:0][7:0] data;
	} frame_t;

	typedef struct packed {
		logic [7:0]  command_type_code;
		logic [10:0] first_frame_id;
		logic [10:0] second_frame_id;
	} cfg_t;

	typedef struct packed {
		logic [31:0] frequency_hz;
		logic [7:0]  tx_power;
		logic [7:0]  modulation;
		logic [7:0]  bandwidth;
		logic [7:0]  spreading_factor;
		logic [7:0]  coding_rate;
		logic [7:0]  test_id;
	} pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfca_if.sv =====
// Handshake channels of the command assembler: received frames, results, register writes.
// Depends on tfca_pkg for the register port widths.
`timescale 1ns / 1ps
`default_nettype none

interface tfca_frame_if;
	logic        valid;
	logic        ready;
	logic [10:0] frame_id;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;
	logic [7:0]  byte5;
	logic [7:0]  byte6;
	logic [7:0]  byte7;

	modport source (output valid, output frame_id, output byte0, output byte1, output byte2,
		output byte3, output byte4, output byte5, output byte6, output byte7, input ready);
	modport sink (input valid, input frame_id, input byte0, input byte1, input byte2,
		input byte3, input byte4, input byte5, input byte6, input byte7, output ready);
endinterface

interface tfca_result_if;
	logic        valid;
	logic        ready;
	logic        msg_kind;
	logic [31:0] frequency_hz;
	logic [7:0]  tx_power;
	logic [7:0]  modulation;
	logic [7:0]  bandwidth;
	logic [7:0]  spreading_factor;
	logic [7:0]  coding_rate;
	logic [2:0]  payload_length;
	logic [7:0]  test_id;
	logic        last;

	modport source (output valid, output msg_kind, output frequency_hz, output tx_power,
		output modulation, output bandwidth, output spreading_factor, output coding_rate,
		output payload_length, output test_id, output last, input ready);
	modport sink (input valid, input msg_kind, input frequency_hz, input tx_power,
		input modulation, input bandwidth, input spreading_factor, input coding_rate,
		input payload_length, input test_id, input last, output ready);
endinterface

interface tfca_cfg_if
	import tfca_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tfca_decode.sv =====
// Frame decoder: header/trailer matching, held header bytes, checksum and frequency scaling.
// Depends on tfca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfca_decode
	import tfca_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire frame_t frame_s1,
	input  wire logic   fire,
	output logic        emit,
	output pair_t       pair
);

	logic            awaiting_q;
	logic [7:0][7:0] held_q;
	logic            is_header;
	logic            is_trailer;
	logic [7:0]      sum;
	logic [15:0]     tenths;
	logic [32:0]     product;

	assign is_header  = (frame_s1.frame_id == cfg.first_frame_id)
		&& (frame_s1.data[0] == cfg.command_type_code);
	assign is_trailer = (frame_s1.frame_id == cfg.second_frame_id)
		&& (frame_s1.data[0] == TRAILER_MARK);

	assign sum = ((held_q[0] + held_q[1]) + (held_q[2] + held_q[3]))
		+ ((held_q[4] + held_q[5]) + (held_q[6] + held_q[7]))
		+ (frame_s1.data[1] + frame_s1.data[2]);

	assign emit = fire && awaiting_q && is_trailer && (sum == frame_s1.data[3]);

	assign tenths  = {held_q[3], held_q[4]};
	assign product = {17'd0, tenths} * {16'd0, HZ_PER_TENTH_MHZ};

	always_comb begin
		pair.frequency_hz     = product[31:0];
		pair.tx_power         = held_q[5];
		pair.modulation       = held_q[6];
		pair.bandwidth        = held_q[7];
		pair.spreading_factor = frame_s1.data[1];
		pair.coding_rate      = frame_s1.data[2];
		pair.test_id          = held_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
		end else if (fire) begin
			awaiting_q <= !awaiting_q && is_header;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !awaiting_q && is_header) begin
			held_q <= frame_s1.data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tfca_out.sv =====
// Result buffer: holds one completed command and delivers its configure and test-data beats.
// Depends on tfca_pkg and the result interface in tfca_if.
`timescale 1ns / 1ps
`default_nettype none

module tfca_out
	import tfca_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire pair_t     pair,
	output logic           free,
	tfca_result_if.source  result
);

	logic  valid_q;
	logic  second_q;
	pair_t pair_q;

	assign free = !valid_q || (second_q && result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q  <= 1'b1;
			second_q <= 1'b0;
		end else if (valid_q && result.ready) begin
			if (second_q) begin
				valid_q <= 1'b0;
			end
			second_q <= !second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pair_q <= pair;
		end
	end

	always_comb begin
		result.valid            = valid_q;
		result.last             = second_q;
		result.msg_kind         = second_q ? MSG_TEST_DATA : MSG_CONFIGURE;
		result.payload_length   = second_q ? PAYLOAD_LEN_TEST : PAYLOAD_LEN_CFG;
		result.test_id          = second_q ? pair_q.test_id : 8'd0;
		result.frequency_hz     = second_q ? 32'd0 : pair_q.frequency_hz;
		result.tx_power         = second_q ? 8'd0 : pair_q.tx_power;
		result.modulation       = second_q ? 8'd0 : pair_q.modulation;
		result.bandwidth        = second_q ? 8'd0 : pair_q.bandwidth;
		result.spreading_factor = second_q ? 8'd0 : pair_q.spreading_factor;
		result.coding_rate      = second_q ? 8'd0 : pair_q.coding_rate;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/two_frame_command_assembler.sv =====
// Top level of the two-frame command assembler: input register, registers, decoder, buffer.
// Depends on tfca_pkg, tfca_if, tfca_decode and tfca_out.
//
// Each beat on the frame channel is one received CAN frame. A header frame is held
// until the next frame arrives; if that frame is a trailer whose checksum matches,
// the result channel carries two beats: a configure beat, then a test-data beat
// with last set. Any other frame after a header drops the held header silently.
// The cfg channel writes the three match registers and is always ready.
// A frame is held in the input register and decoded from there; a matching pair
// loads the result buffer, which presents the configure beat and, once that beat
// is taken, the test-data beat. Frames are taken one per cycle while the result
// buffer is free; while a completed command drains, the next frame waits in the
// input register until the second beat is taken.
// When the receiver stalls, the result beat stays put and the input register
// fills, after which frame ready drops. Reset returns the decoder to idle,
// empties both registers and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module two_frame_command_assembler
	import tfca_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	tfca_frame_if.sink    frame,
	tfca_result_if.source result,
	tfca_cfg_if.sink      cfg
);

	cfg_t   cfg_q;
	logic   s1_valid_q;
	frame_t frame_s1;
	logic   buf_free;
	logic   fire;
	logic   emit;
	pair_t  pair;

	assign cfg.ready   = 1'b1;
	assign fire        = s1_valid_q && buf_free;
	assign frame.ready = !s1_valid_q || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_type_code <= 8'd1;
			cfg_q.first_frame_id    <= 11'd512;
			cfg_q.second_frame_id   <= 11'd513;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_COMMAND_TYPE: cfg_q.command_type_code <= cfg.data[7:0];
				CFG_FIRST_ID:     cfg_q.first_frame_id    <= cfg.data;
				CFG_SECOND_ID:    cfg_q.second_frame_id   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (frame.ready) begin
			s1_valid_q <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			frame_s1.frame_id <= frame.frame_id;
			frame_s1.data     <= {frame.byte7, frame.byte6, frame.byte5, frame.byte4,
				frame.byte3, frame.byte2, frame.byte1, frame.byte0};
		end
	end

	tfca_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.frame_s1 (frame_s1),
		.fire     (fire),
		.emit     (emit),
		.pair     (pair)
	);

	tfca_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.pair   (pair),
		.free   (buf_free),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for two_frame_command_assembler: header/trailer pairs, noise frames,
// register writes and random stalls, with results predicted cycle-free and compared in order.
// Depends on tfca_pkg and the tfca_frame_if, tfca_result_if and tfca_cfg_if interfaces.

module tb_top;
	import tfca_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CHOKE_CYCLES = 200;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct packed {
		logic        msg_kind;
		logic [31:0] frequency_hz;
		logic [7:0]  tx_power;
		logic [7:0]  modulation;
		logic [7:0]  bandwidth;
		logic [7:0]  spreading_factor;
		logic [7:0]  coding_rate;
		logic [2:0]  payload_length;
		logic [7:0]  test_id;
		logic        last;
	} beat_t;

	logic clk;
	logic arst_n;

	tfca_frame_if  frame_ch();
	tfca_result_if result_ch();
	tfca_cfg_if    cfg_ch();

	two_frame_command_assembler uut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	frame_t pending_frames[$];
	beat_t  expected_beats[$];

	logic [7:0]      type_code;
	logic [10:0]     header_id;
	logic [10:0]     trailer_id;
	logic            holding;
	logic [7:0][7:0] header_held;

	logic        frame_fire;
	logic        result_fire;
	bit          send_burst;
	bit          take_burst;
	bit          choke_req;
	int unsigned send_wait;
	int unsigned take_wait;
	int unsigned choke_left;
	int unsigned cycle_count;
	int unsigned errors;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic assemble_frame(input frame_t f);
		logic [7:0] sum;
		beat_t      cfg_beat;
		beat_t      test_beat;
		if (!holding) begin
			if (f.frame_id == header_id && f.data[0] == type_code) begin
				header_held = f.data;
				holding = 1'b1;
			end
		end else begin
			holding = 1'b0;
			if (f.frame_id == trailer_id && f.data[0] == TRAILER_MARK) begin
				sum = f.data[1] + f.data[2];
				for (int i = 0; i < 8; i++)
					sum = sum + header_held[i];
				if (sum == f.data[3]) begin
					cfg_beat = '0;
					cfg_beat.msg_kind = MSG_CONFIGURE;
					cfg_beat.frequency_hz = {16'd0, header_held[3], header_held[4]} *
						32'(HZ_PER_TENTH_MHZ);
					cfg_beat.tx_power = header_held[5];
					cfg_beat.modulation = header_held[6];
					cfg_beat.bandwidth = header_held[7];
					cfg_beat.spreading_factor = f.data[1];
					cfg_beat.coding_rate = f.data[2];
					cfg_beat.payload_length = PAYLOAD_LEN_CFG;
					test_beat = '0;
					test_beat.msg_kind = MSG_TEST_DATA;
					test_beat.payload_length = PAYLOAD_LEN_TEST;
					test_beat.test_id = header_held[2];
					test_beat.last = 1'b1;
					expected_beats.push_back(cfg_beat);
					expected_beats.push_back(test_beat);
				end
			end
		end
	endtask

	always @(posedge clk) begin : frame_tap
		frame_fire <= frame_ch.valid && frame_ch.ready;
		if (arst_n && frame_ch.valid && frame_ch.ready)
			assemble_frame({frame_ch.frame_id, frame_ch.byte7, frame_ch.byte6, frame_ch.byte5,
				frame_ch.byte4, frame_ch.byte3, frame_ch.byte2, frame_ch.byte1, frame_ch.byte0});
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				CFG_COMMAND_TYPE: type_code = cfg_ch.data[7:0];
				CFG_FIRST_ID: header_id = cfg_ch.data[10:0];
				CFG_SECOND_ID: trailer_id = cfg_ch.data[10:0];
				default: ;
			endcase
		end
	end

	always @(negedge clk) begin : sender
		frame_t nxt;
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
		end else if (!frame_ch.valid || frame_fire) begin
			if (frame_fire)
				send_wait = send_burst ? 0 : $urandom_range(0, 9);
			if (send_wait == 0 && pending_frames.size() != 0) begin
				nxt = pending_frames.pop_front();
				frame_ch.frame_id <= nxt.frame_id;
				frame_ch.byte0 <= nxt.data[0];
				frame_ch.byte1 <= nxt.data[1];
				frame_ch.byte2 <= nxt.data[2];
				frame_ch.byte3 <= nxt.data[3];
				frame_ch.byte4 <= nxt.data[4];
				frame_ch.byte5 <= nxt.data[5];
				frame_ch.byte6 <= nxt.data[6];
				frame_ch.byte7 <= nxt.data[7];
				frame_ch.valid <= 1'b1;
			end else begin
				if (send_wait > 0)
					send_wait--;
				frame_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (choke_req) begin
			choke_left = CHOKE_CYCLES;
			choke_req = 1'b0;
		end
		if (result_fire)
			take_wait = take_burst ? 0 : $urandom_range(0, 9);
		if (choke_left > 0) begin
			choke_left--;
			result_ch.ready <= 1'b0;
		end else if (take_wait > 0) begin
			take_wait--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		beat_t want;
		result_fire <= result_ch.valid && result_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t ns: result beat with none expected, expected nothing, actual %0h",
					$time, result_ch.frequency_hz);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				check_field("msg_kind", want.msg_kind, result_ch.msg_kind);
				check_field("frequency_hz", want.frequency_hz, result_ch.frequency_hz);
				check_field("tx_power", want.tx_power, result_ch.tx_power);
				check_field("modulation", want.modulation, result_ch.modulation);
				check_field("bandwidth", want.bandwidth, result_ch.bandwidth);
				check_field("spreading_factor", want.spreading_factor,
					result_ch.spreading_factor);
				check_field("coding_rate", want.coding_rate, result_ch.coding_rate);
				check_field("payload_length", want.payload_length, result_ch.payload_length);
				check_field("test_id", want.test_id, result_ch.test_id);
				check_field("last", want.last, result_ch.last);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic frame_t header_frame();
		frame_t h;
		h.frame_id = header_id;
		h.data = {$urandom, $urandom};
		h.data[0] = type_code;
		case ($urandom_range(0, 7))
			0: {h.data[3], h.data[4]} = 16'hFFFF;
			1: {h.data[3], h.data[4]} = 16'h0000;
			default: ;
		endcase
		return h;
	endfunction

	function automatic frame_t trailer_frame(input frame_t h, input logic [7:0] sf,
		input logic [7:0] cr, input bit intact);
		frame_t     t;
		logic [7:0] sum;
		sum = sf + cr;
		for (int i = 0; i < 8; i++)
			sum = sum + h.data[i];
		t.frame_id = trailer_id;
		t.data = {$urandom, $urandom};
		t.data[0] = TRAILER_MARK;
		t.data[1] = sf;
		t.data[2] = cr;
		t.data[3] = intact ? sum : sum ^ 8'($urandom_range(1, 255));
		return t;
	endfunction

	function automatic frame_t noise_frame();
		frame_t n;
		n.frame_id = 11'($urandom);
		n.data = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: n.frame_id = header_id;
			1: begin
				n.frame_id = trailer_id;
				n.data[0] = TRAILER_MARK;
			end
			default: ;
		endcase
		return n;
	endfunction

	task automatic queue_random(input int unsigned target);
		int unsigned made;
		int unsigned pick;
		frame_t      hdr;
		made = 0;
		while (made < target) begin
			pick = $urandom_range(0, 99);
			hdr = header_frame();
			if (pick < 60) begin
				pending_frames.push_back(hdr);
				pending_frames.push_back(trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b1));
				made += 2;
			end else if (pick < 70) begin
				pending_frames.push_back(hdr);
				pending_frames.push_back(trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b0));
				made += 2;
			end else if (pick < 77) begin
				pending_frames.push_back(hdr);
				pending_frames.push_back(noise_frame());
				made += 2;
			end else if (pick < 82) begin
				pending_frames.push_back(hdr);
				pending_frames.push_back(header_frame());
				made += 2;
			end else if (pick < 92) begin
				pending_frames.push_back(noise_frame());
			end else begin
				pending_frames.push_back(trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b1));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0 || frame_ch.valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		frame_t hdr;
		frame_t tlr;
		logic [10:0] shared_id;
		frame_ch.valid = 1'b0;
		frame_ch.frame_id = '0;
		frame_ch.byte0 = '0;
		frame_ch.byte1 = '0;
		frame_ch.byte2 = '0;
		frame_ch.byte3 = '0;
		frame_ch.byte4 = '0;
		frame_ch.byte5 = '0;
		frame_ch.byte6 = '0;
		frame_ch.byte7 = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		type_code = 8'd1;
		header_id = 11'd512;
		trailer_id = 11'd513;
		holding = 1'b0;
		header_held = '0;
		frame_fire = 1'b0;
		result_fire = 1'b0;
		send_burst = 1'b0;
		take_burst = 1'b0;
		choke_req = 1'b0;
		send_wait = 0;
		take_wait = 0;
		choke_left = 0;
		cycle_count = 0;
		errors = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		hdr = header_frame();
		hdr.data[7:1] = '0;
		pending_frames.push_back(hdr);
		pending_frames.push_back(trailer_frame(hdr, 8'h00, 8'h00, 1'b1));
		hdr = header_frame();
		hdr.data[7:1] = '1;
		pending_frames.push_back(hdr);
		pending_frames.push_back(trailer_frame(hdr, 8'hFF, 8'hFF, 1'b1));
		hdr = header_frame();
		pending_frames.push_back(hdr);
		pending_frames.push_back(trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b0));
		hdr = header_frame();
		tlr = trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b1);
		tlr.data[0] = ~TRAILER_MARK;
		pending_frames.push_back(hdr);
		pending_frames.push_back(tlr);
		hdr = header_frame();
		tlr = trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b1);
		tlr.frame_id = ~trailer_id;
		pending_frames.push_back(hdr);
		pending_frames.push_back(tlr);
		pending_frames.push_back(header_frame());
		hdr = header_frame();
		pending_frames.push_back(hdr);
		pending_frames.push_back(trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b1));
		pending_frames.push_back('0);
		pending_frames.push_back('1);
		hdr = header_frame();
		hdr.data[0] = ~type_code;
		pending_frames.push_back(hdr);
		pending_frames.push_back(trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b1));
		pending_frames.push_back(header_frame());
		pending_frames.push_back('1);
		hdr = header_frame();
		pending_frames.push_back(hdr);
		pending_frames.push_back(trailer_frame(hdr, 8'($urandom), 8'($urandom), 1'b1));
		queue_random(100);
		wait_drained();

		write_register(CFG_COMMAND_TYPE, {3'($urandom), 8'h00});
		write_register(CFG_FIRST_ID, 11'd0);
		write_register(CFG_SECOND_ID, 11'h7FF);
		send_burst = 1'b1;
		queue_random(100);
		wait_drained();

		write_register(CFG_COMMAND_TYPE, {3'($urandom), 8'hFF});
		write_register(CFG_FIRST_ID, 11'h7FF);
		write_register(CFG_SECOND_ID, 11'd0);
		take_burst = 1'b1;
		@(posedge clk);
		choke_req = 1'b1;
		queue_random(120);
		wait_drained();

		shared_id = 11'($urandom);
		write_register(CFG_COMMAND_TYPE, {3'($urandom), TRAILER_MARK});
		write_register(CFG_FIRST_ID, shared_id);
		write_register(CFG_SECOND_ID, shared_id);
		write_register(CFG_UNUSED_IDX, 11'($urandom));
		send_burst = 1'b0;
		take_burst = 1'b0;
		queue_random(80);
		wait_drained();

		repeat (2) begin
			write_register(CFG_COMMAND_TYPE, 11'($urandom));
			write_register(CFG_FIRST_ID, 11'($urandom));
			write_register(CFG_SECOND_ID, 11'($urandom));
			send_burst = $urandom_range(0, 1);
			take_burst = $urandom_range(0, 1);
			queue_random(100);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
